/* rtl/json_byte_tokenizer_defines.svh */
// assertion macros shared by the tokenizer rtl
`ifndef JSON_BYTE_TOKENIZER_DEFINES_SVH
`define JSON_BYTE_TOKENIZER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define JBT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define JBT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/jbt_pkg.sv */
package jbt_pkg;

    // scan modes
    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_NEG     = 4'd1,
        M_INT     = 4'd2,
        M_DOT     = 4'd3,
        M_FRAC    = 4'd4,
        M_EXP     = 4'd5,
        M_EXPSIGN = 4'd6,
        M_EXPDIG  = 4'd7,
        M_STR     = 4'd8,
        M_ESC     = 4'd9,
        M_HEX     = 4'd10,
        M_CHOPEN  = 4'd11,
        M_CHCLOSE = 4'd12,
        M_WORD    = 4'd13,
        M_HALT    = 4'd14
    } t_mode;

    // token kinds
    localparam logic [3:0] KIND_NONE      = 4'd0;
    localparam logic [3:0] KIND_LBRACKET  = 4'd1;
    localparam logic [3:0] KIND_RBRACKET  = 4'd2;
    localparam logic [3:0] KIND_LBRACE    = 4'd3;
    localparam logic [3:0] KIND_RBRACE    = 4'd4;
    localparam logic [3:0] KIND_COLON     = 4'd5;
    localparam logic [3:0] KIND_COMMA     = 4'd6;
    localparam logic [3:0] KIND_STR_START = 4'd7;
    localparam logic [3:0] KIND_STR_CHAR  = 4'd8;
    localparam logic [3:0] KIND_STR_END   = 4'd9;
    localparam logic [3:0] KIND_NUM_CHAR  = 4'd10;
    localparam logic [3:0] KIND_INT_END   = 4'd11;
    localparam logic [3:0] KIND_FLOAT_END = 4'd12;
    localparam logic [3:0] KIND_WORD      = 4'd13;
    localparam logic [3:0] KIND_CHAR      = 4'd14;
    localparam logic [3:0] KIND_ERROR     = 4'd15;

    // error codes
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_EXP_DIGIT   = 3'd1;
    localparam logic [2:0] ERR_BAD_ESCAPE  = 3'd2;
    localparam logic [2:0] ERR_BAD_UNICODE = 3'd3;
    localparam logic [2:0] ERR_BAD_SYMBOL  = 3'd4;

    // word codes
    localparam logic [1:0] WORD_TRUE  = 2'd0;
    localparam logic [1:0] WORD_FALSE = 2'd1;
    localparam logic [1:0] WORD_NULL  = 2'd2;

    // depth of the result queue
    localparam int RESULT_DEPTH = 4;

    // scanner state carried from byte to byte
    typedef struct packed {
        t_mode       mode;
        logic [2:0]  word_index;
        logic [1:0]  word_select;
        logic [2:0]  hex_count;
        logic [7:0]  hex_accum;
        logic        number_is_float;
    } t_scan;

    // one token event without position
    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] value;
        logic [2:0] err;
    } t_event;

    // everything the step logic produces for one byte
    typedef struct packed {
        logic [1:0] count;
        t_event     ev0;
        t_event     ev1;
        logic       new_line;
        logic       advance;
    } t_step_out;

    // one result as queued for the output channel
    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  value;
        logic [2:0]  err;
        logic [15:0] line;
        logic [15:0] column;
        logic        last;
    } t_result;

endpackage

/* rtl/jbt_if.sv */
// input channel: one text byte per request
interface jbt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

// output channel: one token event per request
interface jbt_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [7:0]  token_value;
    logic [2:0]  error_code;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic        last_of_run;

    modport source (output valid, output token_kind, output token_value,
                    output error_code, output line_number, output column_number,
                    output last_of_run, input ready);
    modport sink (input valid, input token_kind, input token_value,
                  input error_code, input line_number, input column_number,
                  input last_of_run, output ready);
endinterface

/* rtl/jbt_step.sv */
module jbt_step (
    input  jbt_pkg::t_scan     i_state,
    input  logic [7:0]         i_byte,
    input  logic               i_eot,
    output jbt_pkg::t_scan     o_next,
    output jbt_pkg::t_step_out o_out
);
    import jbt_pkg::*;

    function automatic t_event mk_ev(logic [3:0] kind, logic [7:0] value, logic [2:0] err);
        t_event e;
        e.kind  = kind;
        e.value = value;
        e.err   = err;
        return e;
    endfunction

    // expected letter of true, false or null
    function automatic logic [7:0] word_char(logic [1:0] sel, logic [2:0] idx);
        logic [7:0] c;
        case ({sel, idx})
            {WORD_TRUE, 3'd0}:  c = 8'h74;
            {WORD_TRUE, 3'd1}:  c = 8'h72;
            {WORD_TRUE, 3'd2}:  c = 8'h75;
            {WORD_TRUE, 3'd3}:  c = 8'h65;
            {WORD_FALSE, 3'd0}: c = 8'h66;
            {WORD_FALSE, 3'd1}: c = 8'h61;
            {WORD_FALSE, 3'd2}: c = 8'h6C;
            {WORD_FALSE, 3'd3}: c = 8'h73;
            {WORD_FALSE, 3'd4}: c = 8'h65;
            {WORD_NULL, 3'd0}:  c = 8'h6E;
            {WORD_NULL, 3'd1}:  c = 8'h75;
            {WORD_NULL, 3'd2}:  c = 8'h6C;
            {WORD_NULL, 3'd3}:  c = 8'h6C;
            default:            c = 8'h00;
        endcase
        return c;
    endfunction

    t_scan      n;
    t_event     ev_a, ev_b, ev_c;
    logic       va, vb, vc;
    logic       start, nl, adv;
    logic       is_digit;
    logic [2:0] word_len;
    logic [2:0] idx_inc;
    logic [2:0] hex_inc;
    logic [3:0] hex_val;
    logic       hex_ok;
    logic [7:0] acc_new;
    logic [3:0] end_kind;

    // digit and hex classification
    always_comb begin
        is_digit = i_byte inside {[8'h30:8'h39]};
        hex_ok   = 1'b1;
        if (is_digit) begin
            hex_val = i_byte[3:0];
        end else if (i_byte inside {[8'h61:8'h66]}) begin
            hex_val = 4'(i_byte - 8'h57);
        end else if (i_byte inside {[8'h41:8'h46]}) begin
            hex_val = 4'(i_byte - 8'h37);
        end else begin
            hex_val = 4'd0;
            hex_ok  = 1'b0;
        end
        word_len = (i_state.word_select == WORD_FALSE) ? 3'd5 : 3'd4;
        idx_inc  = i_state.word_index + 3'd1;
        hex_inc  = i_state.hex_count + 3'd1;
        acc_new  = {i_state.hex_accum[3:0], hex_val};
        end_kind = i_state.number_is_float ? KIND_FLOAT_END : KIND_INT_END;
    end

    // mode update and event selection for one byte
    always_comb begin
        n     = i_state;
        ev_a  = '0;
        ev_b  = '0;
        ev_c  = '0;
        va    = 1'b0;
        vb    = 1'b0;
        vc    = 1'b0;
        start = 1'b0;
        nl    = 1'b0;
        adv   = 1'b1;

        case (i_state.mode)
            M_NEG, M_EXPSIGN: begin
                va = 1'b1;
                if (is_digit) begin
                    ev_a   = mk_ev(KIND_NUM_CHAR, i_byte, ERR_NONE);
                    n.mode = (i_state.mode == M_NEG) ? M_INT : M_EXPDIG;
                end else begin
                    ev_a   = mk_ev(KIND_ERROR, i_byte, ERR_EXP_DIGIT);
                    n.mode = M_HALT;
                end
            end
            M_INT, M_FRAC: begin
                va = 1'b1;
                if (is_digit) begin
                    ev_a = mk_ev(KIND_NUM_CHAR, i_byte, ERR_NONE);
                end else if (i_byte == 8'h2E && i_state.mode == M_INT) begin
                    ev_a   = mk_ev(KIND_NUM_CHAR, i_byte, ERR_NONE);
                    n.mode = M_DOT;
                end else if (i_byte == 8'h65 || i_byte == 8'h45) begin
                    ev_a              = mk_ev(KIND_NUM_CHAR, i_byte, ERR_NONE);
                    n.number_is_float = 1'b1;
                    n.mode            = M_EXP;
                end else begin
                    ev_a   = mk_ev(end_kind, 8'h00, ERR_NONE);
                    n.mode = M_IDLE;
                    start  = 1'b1;
                end
            end
            M_DOT: begin
                va = 1'b1;
                if (is_digit) begin
                    ev_a              = mk_ev(KIND_NUM_CHAR, i_byte, ERR_NONE);
                    n.number_is_float = 1'b1;
                    n.mode            = M_FRAC;
                end else begin
                    ev_a   = mk_ev(KIND_ERROR, 8'h2E, ERR_BAD_SYMBOL);
                    n.mode = M_HALT;
                end
            end
            M_EXP: begin
                va = 1'b1;
                if (is_digit) begin
                    ev_a   = mk_ev(KIND_NUM_CHAR, i_byte, ERR_NONE);
                    n.mode = M_EXPDIG;
                end else if (i_byte == 8'h2B || i_byte == 8'h2D) begin
                    ev_a   = mk_ev(KIND_NUM_CHAR, i_byte, ERR_NONE);
                    n.mode = M_EXPSIGN;
                end else begin
                    ev_a   = mk_ev(end_kind, 8'h00, ERR_NONE);
                    n.mode = M_IDLE;
                    start  = 1'b1;
                end
            end
            M_EXPDIG: begin
                va = 1'b1;
                if (is_digit) begin
                    ev_a = mk_ev(KIND_NUM_CHAR, i_byte, ERR_NONE);
                end else begin
                    ev_a   = mk_ev(end_kind, 8'h00, ERR_NONE);
                    n.mode = M_IDLE;
                    start  = 1'b1;
                end
            end
            M_STR: begin
                if (i_byte == 8'h22) begin
                    va     = 1'b1;
                    ev_a   = mk_ev(KIND_STR_END, i_byte, ERR_NONE);
                    n.mode = M_IDLE;
                end else if (i_byte == 8'h5C) begin
                    n.mode = M_ESC;
                end else begin
                    va   = 1'b1;
                    ev_a = mk_ev(KIND_STR_CHAR, i_byte, ERR_NONE);
                    nl   = (i_byte == 8'h0A);
                end
            end
            M_ESC: begin
                va     = 1'b1;
                n.mode = M_STR;
                case (i_byte)
                    8'h22, 8'h5C, 8'h2F: ev_a = mk_ev(KIND_STR_CHAR, i_byte, ERR_NONE);
                    8'h62: ev_a = mk_ev(KIND_STR_CHAR, 8'h08, ERR_NONE);
                    8'h66: ev_a = mk_ev(KIND_STR_CHAR, 8'h0C, ERR_NONE);
                    8'h6E: ev_a = mk_ev(KIND_STR_CHAR, 8'h0A, ERR_NONE);
                    8'h72: ev_a = mk_ev(KIND_STR_CHAR, 8'h0D, ERR_NONE);
                    8'h74: ev_a = mk_ev(KIND_STR_CHAR, 8'h09, ERR_NONE);
                    8'h75: begin
                        va          = 1'b0;
                        n.hex_count = 3'd0;
                        n.hex_accum = 8'h00;
                        n.mode      = M_HEX;
                    end
                    default: begin
                        ev_a   = mk_ev(KIND_ERROR, i_byte, ERR_BAD_ESCAPE);
                        n.mode = M_HALT;
                    end
                endcase
            end
            M_HEX: begin
                if (!hex_ok) begin
                    va     = 1'b1;
                    ev_a   = mk_ev(KIND_ERROR, i_byte, ERR_BAD_UNICODE);
                    n.mode = M_HALT;
                end else begin
                    n.hex_accum = acc_new;
                    n.hex_count = hex_inc;
                    if (hex_inc >= 3'd4) begin
                        va          = 1'b1;
                        ev_a        = mk_ev(KIND_STR_CHAR, acc_new, ERR_NONE);
                        n.hex_count = 3'd0;
                        n.mode      = M_STR;
                    end
                end
            end
            M_CHOPEN: begin
                n.hex_accum = i_byte;
                n.mode      = M_CHCLOSE;
            end
            M_CHCLOSE: begin
                if (i_byte == 8'h20 || i_byte == 8'h09 || i_byte == 8'h0D) begin
                    n.mode = M_CHCLOSE;
                end else if (i_byte == 8'h0A) begin
                    nl = 1'b1;
                end else if (i_byte == 8'h27) begin
                    va     = 1'b1;
                    ev_a   = mk_ev(KIND_CHAR, i_state.hex_accum, ERR_NONE);
                    n.mode = M_IDLE;
                end else begin
                    va     = 1'b1;
                    ev_a   = mk_ev(KIND_ERROR, i_byte, ERR_BAD_SYMBOL);
                    n.mode = M_HALT;
                end
            end
            M_WORD: begin
                if (i_state.word_select == 2'd3 || i_state.word_index >= word_len
                        || i_byte != word_char(i_state.word_select, i_state.word_index)) begin
                    va     = 1'b1;
                    ev_a   = mk_ev(KIND_ERROR, i_byte, ERR_BAD_SYMBOL);
                    n.mode = M_HALT;
                end else begin
                    n.word_index = idx_inc;
                    if (idx_inc >= word_len) begin
                        va           = 1'b1;
                        ev_a         = mk_ev(KIND_WORD, {6'd0, i_state.word_select}, ERR_NONE);
                        n.word_index = 3'd0;
                        n.mode       = M_IDLE;
                    end
                end
            end
            M_HALT: begin
                adv = 1'b0;
            end
            default: begin
                n.mode = M_IDLE;
                start  = 1'b1;
            end
        endcase

        // start of a new token
        if (start) begin
            case (i_byte)
                8'h20, 8'h09, 8'h0D: nl = 1'b0;
                8'h0A: nl = 1'b1;
                8'h5B: begin vb = 1'b1; ev_b = mk_ev(KIND_LBRACKET, i_byte, ERR_NONE); end
                8'h5D: begin vb = 1'b1; ev_b = mk_ev(KIND_RBRACKET, i_byte, ERR_NONE); end
                8'h7B: begin vb = 1'b1; ev_b = mk_ev(KIND_LBRACE, i_byte, ERR_NONE); end
                8'h7D: begin vb = 1'b1; ev_b = mk_ev(KIND_RBRACE, i_byte, ERR_NONE); end
                8'h3A: begin vb = 1'b1; ev_b = mk_ev(KIND_COLON, i_byte, ERR_NONE); end
                8'h2C: begin vb = 1'b1; ev_b = mk_ev(KIND_COMMA, i_byte, ERR_NONE); end
                8'h22: begin
                    vb     = 1'b1;
                    ev_b   = mk_ev(KIND_STR_START, i_byte, ERR_NONE);
                    n.mode = M_STR;
                end
                8'h27: n.mode = M_CHOPEN;
                8'h2D: begin
                    vb = 1'b1;
                    if (i_eot) begin
                        ev_b   = mk_ev(KIND_ERROR, i_byte, ERR_EXP_DIGIT);
                        n.mode = M_HALT;
                    end else begin
                        ev_b              = mk_ev(KIND_NUM_CHAR, i_byte, ERR_NONE);
                        n.number_is_float = 1'b0;
                        n.mode            = M_NEG;
                    end
                end
                8'h74: begin n.word_select = WORD_TRUE;  n.word_index = 3'd1; n.mode = M_WORD; end
                8'h66: begin n.word_select = WORD_FALSE; n.word_index = 3'd1; n.mode = M_WORD; end
                8'h6E: begin n.word_select = WORD_NULL;  n.word_index = 3'd1; n.mode = M_WORD; end
                default: begin
                    vb = 1'b1;
                    if (is_digit) begin
                        ev_b              = mk_ev(KIND_NUM_CHAR, i_byte, ERR_NONE);
                        n.number_is_float = 1'b0;
                        n.mode            = M_INT;
                    end else begin
                        ev_b   = mk_ev(KIND_ERROR, i_byte, ERR_BAD_SYMBOL);
                        n.mode = M_HALT;
                    end
                end
            endcase
        end

        // final byte flushes an open number, or raises an error on an unfinished one
        if (i_eot && adv) begin
            case (n.mode)
                M_INT, M_FRAC, M_EXP, M_EXPDIG: begin
                    vc     = 1'b1;
                    ev_c   = mk_ev(n.number_is_float ? KIND_FLOAT_END : KIND_INT_END,
                                   8'h00, ERR_NONE);
                    n.mode = M_IDLE;
                end
                M_NEG, M_EXPSIGN: begin
                    vc     = 1'b1;
                    ev_c   = mk_ev(KIND_ERROR, i_byte, ERR_EXP_DIGIT);
                    n.mode = M_HALT;
                end
                M_DOT: begin
                    vc     = 1'b1;
                    ev_c   = mk_ev(KIND_ERROR, 8'h2E, ERR_BAD_SYMBOL);
                    n.mode = M_HALT;
                end
                default: vc = 1'b0;
            endcase
        end
    end

    // pack the first two events in order
    always_comb begin
        o_next         = n;
        o_out.new_line = nl;
        o_out.advance  = adv;
        o_out.ev0      = va ? ev_a : (vb ? ev_b : ev_c);
        o_out.ev1      = va ? (vb ? ev_b : ev_c) : ev_c;
        case ({va, vb, vc})
            3'b000:                      o_out.count = 2'd0;
            3'b100, 3'b010, 3'b001:      o_out.count = 2'd1;
            default:                     o_out.count = 2'd2;
        endcase
    end

endmodule

/* rtl/jbt_result_fifo.sv */
module jbt_result_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_push_count,
    input  jbt_pkg::t_result i_entry0,
    input  jbt_pkg::t_result i_entry1,
    output logic             o_room,
    output logic             o_valid,
    output jbt_pkg::t_result o_entry,
    input  logic             i_ready
);
    import jbt_pkg::*;

    localparam int Depth = RESULT_DEPTH;
    localparam int AddrW = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);

    t_result          r_mem [Depth];
    logic [AddrW-1:0] r_wr;
    logic [AddrW-1:0] r_rd;
    logic [CntW-1:0]  r_count;
    logic             pop;

    // room for the worst case of two results from one byte
    assign o_room  = r_count <= CntW'(Depth - 2);
    assign o_valid = r_count != '0;
    assign o_entry = r_mem[r_rd];
    assign pop     = o_valid & i_ready;

    // storage writes
    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_mem[r_wr] <= i_entry0;
        end
        if (i_push_count == 2'd2) begin
            r_mem[r_wr + AddrW'(1)] <= i_entry1;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + AddrW'(i_push_count);
            r_rd    <= r_rd + AddrW'(pop);
            r_count <= r_count + CntW'(i_push_count) - CntW'(pop);
        end
    end

endmodule

/* rtl/json_byte_tokenizer.sv */
// Streaming JSON tokenizer.
// i_in carries one text byte per request (text_byte, end_of_text); o_out
// carries token events, one per request, each with the line and column of
// the byte that caused it and last_of_run set on that byte's final event.
// A byte causes zero, one or two events; bytes that only advance the scan
// (white space, backslash, word letters) produce nothing on o_out.
// A byte is registered at the input, decoded from that register and its
// events written to a four-entry result queue that drives o_out.
// Throughput: one byte per cycle while each byte yields at most one event
// and o_out is taken every cycle; a byte yielding two events holds the
// output until both have been taken. A byte is decoded only while the
// queue has room for two events.
// Reset (synchronous, active low) empties the queue and returns the scanner
// to between tokens at line 1. After an error event the scanner ignores all
// bytes until reset. A stall on o_out fills the queue and then holds off
// i_in ready; nothing is dropped.
`include "json_byte_tokenizer_defines.svh"

module json_byte_tokenizer #(
    parameter int POSITION_WIDTH = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    jbt_in_if.sink     i_in,
    jbt_out_if.source  o_out
);
    import jbt_pkg::*;

    logic                      r_in_valid;
    logic [7:0]                r_in_byte;
    logic                      r_in_eot;
    t_scan                     r_state;
    t_scan                     n_state;
    logic [POSITION_WIDTH-1:0] r_line;
    logic [POSITION_WIDTH-1:0] r_col;
    logic [POSITION_WIDTH-1:0] n_line;
    logic [POSITION_WIDTH-1:0] n_col;
    logic [POSITION_WIDTH-1:0] col_inc;
    t_step_out                 step;
    t_result                   entry0;
    t_result                   entry1;
    t_result                   out_entry;
    logic                      fifo_room;
    logic                      step_fire;
    logic [1:0]                push_count;
    logic                      halted;
    logic                      err_pushed;
    logic                      lf_taken;

    // input register
    assign step_fire  = r_in_valid & fifo_room;
    assign i_in.ready = !r_in_valid | step_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.text_byte;
            r_in_eot  <= i_in.end_of_text;
        end
    end

    // per-byte decode
    jbt_step u_step (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .i_eot   (r_in_eot),
        .o_next  (n_state),
        .o_out   (step)
    );

    // position counters, saturating
    always_comb begin
        col_inc = (r_col == '1) ? r_col : r_col + POSITION_WIDTH'(1);
        n_line  = r_line;
        n_col   = r_col;
        if (step.advance) begin
            n_col = col_inc;
            if (step.new_line) begin
                n_col = '0;
                if (r_line != '1) begin
                    n_line = r_line + POSITION_WIDTH'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{mode: M_IDLE, word_index: 3'd0, word_select: 2'd0,
                         hex_count: 3'd0, hex_accum: 8'h00, number_is_float: 1'b0};
            r_line  <= POSITION_WIDTH'(1);
            r_col   <= '0;
        end else if (step_fire) begin
            r_state <= n_state;
            r_line  <= n_line;
            r_col   <= n_col;
        end
    end

    // results with position and end-of-run mark
    always_comb begin
        entry0.kind   = step.ev0.kind;
        entry0.value  = step.ev0.value;
        entry0.err    = step.ev0.err;
        entry0.line   = 16'(r_line);
        entry0.column = 16'(col_inc);
        entry0.last   = (step.count == 2'd1);
        entry1.kind   = step.ev1.kind;
        entry1.value  = step.ev1.value;
        entry1.err    = step.ev1.err;
        entry1.line   = 16'(r_line);
        entry1.column = 16'(col_inc);
        entry1.last   = 1'b1;
        push_count    = step_fire ? step.count : 2'd0;
    end

    jbt_result_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (push_count),
        .i_entry0     (entry0),
        .i_entry1     (entry1),
        .o_room       (fifo_room),
        .o_valid      (o_out.valid),
        .o_entry      (out_entry),
        .i_ready      (o_out.ready)
    );

    // output channel
    assign o_out.token_kind    = out_entry.kind;
    assign o_out.token_value   = out_entry.value;
    assign o_out.error_code    = out_entry.err;
    assign o_out.line_number   = out_entry.line;
    assign o_out.column_number = out_entry.column;
    assign o_out.last_of_run   = out_entry.last;

    // checks
    assign halted     = (r_state.mode == M_HALT);
    assign err_pushed = ((push_count != 2'd0) && (step.ev0.kind == KIND_ERROR)) ||
                        ((push_count == 2'd2) && (step.ev1.kind == KIND_ERROR));
    assign lf_taken   = step_fire & step.advance & step.new_line;

    `JBT_ASSERT_NOW(a_halt_silent, step_fire && halted, push_count == 2'd0, "result while halted")
    `JBT_ASSERT_NEXT(a_error_halts, err_pushed, halted, "error did not halt the scanner")
    `JBT_ASSERT_NEXT(a_newline_col, lf_taken, r_col == '0, "column not cleared after a line feed")
    `JBT_ASSERT_NOW(a_line_nonzero, 1'b1, r_line != '0, "line counter reached zero")

endmodule

/* tb/tb_json_byte_tokenizer.sv */
`timescale 1ns / 1ps

module tb_json_byte_tokenizer;
    import jbt_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [15:0] POS_MAX = 16'hFFFF;

    // mirror of the scanner, producing the token events due for each byte
    class token_tracker;
        t_mode       mode;
        logic [2:0]  word_index;
        logic [1:0]  word_select;
        logic [2:0]  hex_count;
        logic [7:0]  hex_accum;
        logic        number_is_float;
        logic [15:0] line_count;
        logic [15:0] column_count;
        logic [15:0] byte_line;
        logic [15:0] byte_column;
        t_result     due_events[$];
        t_result     this_byte[$];
        int          mismatches = 0;

        function void clear();
            mode = M_IDLE;
            word_index = 3'd0;
            word_select = 2'd0;
            hex_count = 3'd0;
            hex_accum = 8'h00;
            number_is_float = 1'b0;
            line_count = 16'd1;
            column_count = 16'd0;
            due_events.delete();
        endfunction

        function void note_mismatch(string msg);
            if (mismatches < 10) begin
                $display("%s", msg);
            end
            mismatches++;
        endfunction

        function void emit_event(logic [3:0] kind, logic [7:0] value, logic [2:0] err);
            t_result r;
            if (this_byte.size() >= 2) return;
            r.kind = kind;
            r.value = value;
            r.err = err;
            r.line = byte_line;
            r.column = byte_column;
            r.last = 1'b0;
            this_byte.push_back(r);
        endfunction

        function void halt_with(logic [2:0] err, logic [7:0] value);
            emit_event(KIND_ERROR, value, err);
            mode = M_HALT;
        endfunction

        function void count_line();
            if (line_count != POS_MAX) line_count++;
            column_count = 16'd0;
        endfunction

        function void close_number();
            emit_event(number_is_float ? KIND_FLOAT_END : KIND_INT_END, 8'h00, ERR_NONE);
            mode = M_IDLE;
        endfunction

        function bit is_digit(logic [7:0] b);
            return b >= "0" && b <= "9";
        endfunction

        function int nibble_of(logic [7:0] b);
            if (b >= "0" && b <= "9") return b - "0";
            if (b >= "a" && b <= "f") return b - "a" + 10;
            if (b >= "A" && b <= "F") return b - "A" + 10;
            return -1;
        endfunction

        function logic [7:0] word_letter(logic [1:0] sel, logic [2:0] idx);
            string w;
            case (sel)
                WORD_TRUE:  w = "true";
                WORD_FALSE: w = "false";
                default:    w = "null";
            endcase
            return w[idx];
        endfunction

        function int word_length(logic [1:0] sel);
            return (sel == WORD_FALSE) ? 5 : 4;
        endfunction

        function void start_word(logic [1:0] sel);
            word_select = sel;
            word_index = 3'd1;
            mode = M_WORD;
        endfunction

        // first byte of a token, or white space between tokens
        function void open_token(logic [7:0] b, bit eot);
            case (b)
                " ", CH_TAB, CH_CR: ;
                CH_LF: count_line();
                "[": emit_event(KIND_LBRACKET, b, ERR_NONE);
                "]": emit_event(KIND_RBRACKET, b, ERR_NONE);
                "{": emit_event(KIND_LBRACE, b, ERR_NONE);
                "}": emit_event(KIND_RBRACE, b, ERR_NONE);
                ":": emit_event(KIND_COLON, b, ERR_NONE);
                ",": emit_event(KIND_COMMA, b, ERR_NONE);
                "\"": begin
                    emit_event(KIND_STR_START, b, ERR_NONE);
                    mode = M_STR;
                end
                "'": mode = M_CHOPEN;
                "-": begin
                    if (eot) begin
                        halt_with(ERR_EXP_DIGIT, b);
                    end else begin
                        emit_event(KIND_NUM_CHAR, b, ERR_NONE);
                        number_is_float = 1'b0;
                        mode = M_NEG;
                    end
                end
                "t": start_word(WORD_TRUE);
                "f": start_word(WORD_FALSE);
                "n": start_word(WORD_NULL);
                default: begin
                    if (is_digit(b)) begin
                        emit_event(KIND_NUM_CHAR, b, ERR_NONE);
                        number_is_float = 1'b0;
                        mode = M_INT;
                    end else begin
                        halt_with(ERR_BAD_SYMBOL, b);
                    end
                end
            endcase
        endfunction

        function void decode_escape(logic [7:0] b);
            logic [7:0] c;
            case (b)
                "\"", "\\", "/": c = b;
                "b": c = CH_BS;
                "f": c = CH_FF;
                "n": c = CH_LF;
                "r": c = CH_CR;
                "t": c = CH_TAB;
                "u": begin
                    hex_count = 3'd0;
                    hex_accum = 8'h00;
                    mode = M_HEX;
                    return;
                end
                default: begin
                    halt_with(ERR_BAD_ESCAPE, b);
                    return;
                end
            endcase
            emit_event(KIND_STR_CHAR, c, ERR_NONE);
            mode = M_STR;
        endfunction

        // one accepted request on the input channel
        function void take_byte(logic [7:0] b, bit eot);
            int h;
            this_byte.delete();
            if (mode == M_HALT) return;
            if (column_count != POS_MAX) column_count++;
            byte_line = line_count;
            byte_column = column_count;

            case (mode)
                M_NEG, M_EXPSIGN: begin
                    if (is_digit(b)) begin
                        emit_event(KIND_NUM_CHAR, b, ERR_NONE);
                        if (mode == M_NEG) mode = M_INT;
                        else mode = M_EXPDIG;
                    end else begin
                        halt_with(ERR_EXP_DIGIT, b);
                    end
                end
                M_INT, M_FRAC: begin
                    if (is_digit(b)) begin
                        emit_event(KIND_NUM_CHAR, b, ERR_NONE);
                    end else if (b == "." && mode == M_INT) begin
                        emit_event(KIND_NUM_CHAR, b, ERR_NONE);
                        mode = M_DOT;
                    end else if (b == "e" || b == "E") begin
                        emit_event(KIND_NUM_CHAR, b, ERR_NONE);
                        number_is_float = 1'b1;
                        mode = M_EXP;
                    end else begin
                        close_number();
                        open_token(b, eot);
                    end
                end
                M_DOT: begin
                    if (is_digit(b)) begin
                        emit_event(KIND_NUM_CHAR, b, ERR_NONE);
                        number_is_float = 1'b1;
                        mode = M_FRAC;
                    end else begin
                        halt_with(ERR_BAD_SYMBOL, ".");
                    end
                end
                M_EXP: begin
                    if (is_digit(b)) begin
                        emit_event(KIND_NUM_CHAR, b, ERR_NONE);
                        mode = M_EXPDIG;
                    end else if (b == "+" || b == "-") begin
                        emit_event(KIND_NUM_CHAR, b, ERR_NONE);
                        mode = M_EXPSIGN;
                    end else begin
                        close_number();
                        open_token(b, eot);
                    end
                end
                M_EXPDIG: begin
                    if (is_digit(b)) begin
                        emit_event(KIND_NUM_CHAR, b, ERR_NONE);
                    end else begin
                        close_number();
                        open_token(b, eot);
                    end
                end
                M_STR: begin
                    if (b == "\"") begin
                        emit_event(KIND_STR_END, b, ERR_NONE);
                        mode = M_IDLE;
                    end else if (b == "\\") begin
                        mode = M_ESC;
                    end else begin
                        emit_event(KIND_STR_CHAR, b, ERR_NONE);
                        if (b == CH_LF) count_line();
                    end
                end
                M_ESC: decode_escape(b);
                M_HEX: begin
                    h = nibble_of(b);
                    if (h < 0) begin
                        halt_with(ERR_BAD_UNICODE, b);
                    end else begin
                        hex_accum = {hex_accum[3:0], h[3:0]};
                        hex_count = hex_count + 3'd1;
                        if (hex_count >= 3'd4) begin
                            emit_event(KIND_STR_CHAR, hex_accum, ERR_NONE);
                            hex_count = 3'd0;
                            mode = M_STR;
                        end
                    end
                end
                M_CHOPEN: begin
                    // literal byte is taken as it stands, even a line feed
                    hex_accum = b;
                    mode = M_CHCLOSE;
                end
                M_CHCLOSE: begin
                    if (b == CH_LF) begin
                        count_line();
                    end else if (b == "'") begin
                        emit_event(KIND_CHAR, hex_accum, ERR_NONE);
                        mode = M_IDLE;
                    end else if (b != " " && b != CH_TAB && b != CH_CR) begin
                        halt_with(ERR_BAD_SYMBOL, b);
                    end
                end
                M_WORD: begin
                    if (word_index >= word_length(word_select) ||
                        b != word_letter(word_select, word_index)) begin
                        halt_with(ERR_BAD_SYMBOL, b);
                    end else begin
                        word_index = word_index + 3'd1;
                        if (word_index >= word_length(word_select)) begin
                            emit_event(KIND_WORD, {6'd0, word_select}, ERR_NONE);
                            word_index = 3'd0;
                            mode = M_IDLE;
                        end
                    end
                end
                default: begin
                    mode = M_IDLE;
                    open_token(b, eot);
                end
            endcase

            // end of text flushes an open number, or halts with an error on an unfinished one
            if (eot) begin
                case (mode)
                    M_INT, M_FRAC, M_EXP, M_EXPDIG: close_number();
                    M_NEG, M_EXPSIGN: halt_with(ERR_EXP_DIGIT, b);
                    M_DOT: halt_with(ERR_BAD_SYMBOL, ".");
                    default: ;
                endcase
            end

            if (this_byte.size() > 0) this_byte[this_byte.size() - 1].last = 1'b1;
            foreach (this_byte[i]) due_events.push_back(this_byte[i]);
        endfunction

        // one accepted request on the output channel
        function void compare_event(t_result got);
            t_result want;
            if (due_events.size() == 0) begin
                note_mismatch($sformatf(
                    "unexpected event: kind %0d value %02h err %0d pos %0d:%0d last %0b",
                    got.kind, got.value, got.err, got.line, got.column, got.last));
                return;
            end
            want = due_events.pop_front();
            if (got.kind !== want.kind || got.value !== want.value ||
                got.err !== want.err || got.line !== want.line ||
                got.column !== want.column || got.last !== want.last) begin
                note_mismatch($sformatf(
                    {"event mismatch: expected kind %0d value %02h err %0d pos %0d:%0d ",
                     "last %0b, got kind %0d value %02h err %0d pos %0d:%0d last %0b"},
                    want.kind, want.value, want.err, want.line, want.column, want.last,
                    got.kind, got.value, got.err, got.line, got.column, got.last));
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    jbt_in_if  in_ch ();
    jbt_out_if out_ch ();

    json_byte_tokenizer #(
        .POSITION_WIDTH(16)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    token_tracker tracker = new;
    logic [7:0]   text_q[$];
    t_result      seen_event;
    bit           steady = 1'b0;
    int           hold_request = 0;
    int           hold_left = 0;
    int           cycle_count = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("json_byte_tokenizer test failed");
            $finish;
        end
    end

    // receiver: random stalls, long hold-off on request, checks each event
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= steady || ($urandom_range(99) >= 9);
            end
            @(posedge i_clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                seen_event.kind = out_ch.token_kind;
                seen_event.value = out_ch.token_value;
                seen_event.err = out_ch.error_code;
                seen_event.line = out_ch.line_number;
                seen_event.column = out_ch.column_number;
                seen_event.last = out_ch.last_of_run;
                tracker.compare_event(seen_event);
            end
        end
    end

    // offer one byte until the block takes it
    task automatic send_byte(input logic [7:0] b, input bit eot);
        @(negedge i_clk);
        if (!steady && $urandom_range(99) < 9) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.text_byte <= b;
        in_ch.end_of_text <= eot;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        tracker.take_byte(b, eot);
    endtask

    task automatic send_queued(input int eot_at);
        foreach (text_q[i]) send_byte(text_q[i], i == eot_at);
        text_q.delete();
    endtask

    function automatic void add_text(string s);
        foreach (s[i]) text_q.push_back(s[i]);
    endfunction

    function automatic logic [7:0] random_digit();
        logic [7:0] d;
        d = 8'($urandom_range(9));
        return "0" + d;
    endfunction

    function automatic logic [7:0] random_blank(bit with_lf);
        case ($urandom_range(with_lf ? 3 : 2))
            0: return " ";
            1: return CH_TAB;
            2: return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // optional minus, digits, optional fraction, optional exponent
    function automatic void add_number();
        if ($urandom_range(3) == 0) text_q.push_back("-");
        repeat ($urandom_range(4, 1)) text_q.push_back(random_digit());
        if ($urandom_range(2) == 0) begin
            text_q.push_back(".");
            repeat ($urandom_range(3, 1)) text_q.push_back(random_digit());
        end
        if ($urandom_range(2) == 0) begin
            text_q.push_back($urandom_range(1) ? "e" : "E");
            case ($urandom_range(3))
                0: ;
                1: repeat ($urandom_range(3, 1)) text_q.push_back(random_digit());
                default: begin
                    text_q.push_back($urandom_range(1) ? "+" : "-");
                    repeat ($urandom_range(3, 1)) text_q.push_back(random_digit());
                end
            endcase
        end
    endfunction

    // string with raw bytes, short escapes and unicode escapes
    function automatic void add_string();
        string      esc_set = "\"\\/bfnrt";
        string      hex_set = "0123456789abcdefABCDEF";
        logic [7:0] c;
        text_q.push_back("\"");
        repeat ($urandom_range(6)) begin
            case ($urandom_range(9))
                0: begin
                    text_q.push_back("\\");
                    text_q.push_back(esc_set[$urandom_range(7)]);
                end
                1: begin
                    add_text("\\u");
                    repeat (4) text_q.push_back(hex_set[$urandom_range(21)]);
                end
                default: begin
                    do c = 8'($urandom_range(255)); while (c == "\"" || c == "\\");
                    text_q.push_back(c);
                end
            endcase
        end
        text_q.push_back("\"");
    endfunction

    function automatic void add_char_literal();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        text_q.push_back("'");
        text_q.push_back(c);
        repeat ($urandom_range(2)) text_q.push_back(random_blank(1'b1));
        text_q.push_back("'");
    endfunction

    function automatic void add_word();
        case ($urandom_range(2))
            0: add_text("true");
            1: add_text("false");
            default: add_text("null");
        endcase
    endfunction

    function automatic void add_punct();
        string p = "[]{}:,";
        text_q.push_back(p[$urandom_range(5)]);
    endfunction

    // stimulus
    initial begin
        int  random_bytes;
        int  pick;
        int  eot_at;
        bit  held;

        in_ch.valid = 1'b0;
        in_ch.text_byte = 8'h00;
        in_ch.end_of_text = 1'b0;
        i_rst_n = 1'b0;
        tracker.clear();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: punctuation, escapes, unicode, signed float, char literal
        // holding a line feed, exponent with no digits, word, end flush
        add_text("[{\"\\u00fF\\t\":-9.0e+1,'");
        text_q.push_back(CH_LF);
        add_text(" '},0E,null]");
        send_queued(text_q.size() - 1);
        add_text("12");
        send_queued(1);

        // random well-formed tokens; any malformed token halts the scanner
        // until reset, so errors are kept for the very end
        random_bytes = 0;
        held = 1'b0;
        while (random_bytes < 1350) begin
            steady = (random_bytes >= 400 && random_bytes < 700);
            if (!held && random_bytes >= 1000) begin
                hold_request = 400;
                held = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 25) add_punct();
            else if (pick < 45) add_string();
            else if (pick < 70) add_number();
            else if (pick < 85) add_word();
            else add_char_literal();
            eot_at = -1;
            if ($urandom_range(99) < 6) begin
                eot_at = text_q.size() - 1;
            end else if (pick >= 25 && (pick < 45 || pick >= 70) &&
                         $urandom_range(99) < 5) begin
                // end of text inside a string, word or char literal
                eot_at = $urandom_range(text_q.size() - 1);
            end
            repeat ($urandom_range(2)) begin
                if ($urandom_range(2) == 0) text_q.push_back(random_blank(1'b1));
            end
            random_bytes += text_q.size();
            send_queued(eot_at);
        end
        steady = 1'b0;

        // one error, then bytes that the halted scanner ignores
        eot_at = -1;
        case ($urandom_range(9))
            0: add_text("-q");
            1: begin
                add_text("-");
                eot_at = 0;
            end
            2: begin
                add_text("3e+");
                eot_at = 2;
            end
            3: add_text("4.x");
            4: begin
                add_text("5.");
                eot_at = 1;
            end
            5: add_text("\"\\q");
            6: add_text("\"\\u0g");
            7: add_text("falsy");
            8: add_text("'ab");
            default: add_text("@");
        endcase
        send_queued(eot_at);
        repeat (4) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));

        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (tracker.due_events.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (tracker.due_events.size() != 0) begin
            tracker.note_mismatch($sformatf("%0d events never arrived",
                                            tracker.due_events.size()));
        end
        if (tracker.mismatches == 0) begin
            $display("json_byte_tokenizer test passed");
        end else begin
            $display("json_byte_tokenizer test failed");
        end
        $finish;
    end

endmodule
